@@ hdl/ssac_pkg.sv @@
// shared types, constants and helper functions for the shaft speed capture unit
`timescale 1ns / 1ps

package ssac_pkg;

    localparam int NUM_W      = 22;
    localparam int PERIOD_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int ACC_W      = 13;
    localparam int MODE_W     = 3;
    localparam int GLITCH_W   = 8;

    localparam logic [MODE_W-1:0] MODE_DIV1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIV3 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV4 = 3'd4;

    localparam logic [NUM_W-1:0] NUM_DIV1 = 22'd500000;
    localparam logic [NUM_W-1:0] NUM_DIV3 = 22'd2000000;
    localparam logic [NUM_W-1:0] NUM_DIV4 = 22'd4000000;

    localparam logic [PERIOD_W-1:0] PERIOD_FAST_MID = 16'd1250;
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW     = 16'd3333;
    localparam logic [PERIOD_W-1:0] PERIOD_FAST_LOW = 16'd625;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 16'hFFFF;

    localparam logic [SPEED_W-1:0] LIMIT_CH0   = 16'd600;
    localparam logic [SPEED_W-1:0] LIMIT_CH1   = 16'd800;
    localparam logic [SPEED_W-1:0] LIMIT_NONE  = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_CEIL  = 16'd8000;
    localparam logic [SPEED_W-1:0] SPEED_FLOOR = 16'd60;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_DIV3;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } ssac_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ssac_stat_t;

    function automatic logic mode_valid(input logic [MODE_W-1:0] mode);
        return (mode == MODE_DIV1) || (mode == MODE_DIV3) || (mode == MODE_DIV4);
    endfunction

    function automatic logic [NUM_W-1:0] numerator_for(input logic [MODE_W-1:0] mode);
        logic [NUM_W-1:0] num;
        case (mode)
            MODE_DIV1: num = NUM_DIV1;
            MODE_DIV3: num = NUM_DIV3;
            MODE_DIV4: num = NUM_DIV4;
            default:   num = '0;
        endcase
        return num;
    endfunction

    function automatic logic [MODE_W-1:0] next_mode(input logic [MODE_W-1:0] mode,
                                                     input logic [PERIOD_W-1:0] period);
        logic [MODE_W-1:0] nxt;
        case (mode)
            MODE_DIV3: begin
                if (period < PERIOD_FAST_MID) nxt = MODE_DIV4;
                else if (period > PERIOD_SLOW) nxt = MODE_DIV1;
                else nxt = MODE_DIV3;
            end
            MODE_DIV4: nxt = (period > PERIOD_SLOW) ? MODE_DIV3 : MODE_DIV4;
            MODE_DIV1: nxt = (period < PERIOD_FAST_LOW) ? MODE_DIV3 : MODE_DIV1;
            default:   nxt = MODE_DIV3;
        endcase
        return nxt;
    endfunction

endpackage

@@ hdl/ssac_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ssac_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssac_pkg::NUM_W-1:0]    dividend,
    input  logic [ssac_pkg::PERIOD_W-1:0] divisor,
    output logic                          done,
    output logic [ssac_pkg::NUM_W-1:0]    quotient
);
    import ssac_pkg::*;

    localparam int STEPS = NUM_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [PERIOD_W-1:0] div_reg, div_next;
    logic [PERIOD_W:0]   shifted;
    logic                fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? PERIOD_W'(shifted - {1'b0, div_reg}) : shifted[PERIOD_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/ssac_dp.sv @@
// datapath: request latch, channel state, speed gating and result register
`timescale 1ns / 1ps

module ssac_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ssac_pkg::ssac_cmd_t           cmd,
    output ssac_pkg::ssac_stat_t          stat,
    input  logic [1:0]                    report_mask,
    input  logic                          in_channel,
    input  logic                          in_capture_ready,
    input  logic [ssac_pkg::PERIOD_W-1:0] in_capture_period,
    input  logic                          in_timer_lapsed,
    output logic                          out_skipped,
    output logic [ssac_pkg::SPEED_W-1:0]  out_raw_speed,
    output logic [ssac_pkg::ACC_W-1:0]    out_accepted_speed,
    output logic [ssac_pkg::SPEED_W-1:0]  out_gate_limit,
    output logic [ssac_pkg::MODE_W-1:0]   out_prescale_mode,
    output logic                          out_mode_changed,
    output logic                          out_expired_set,
    output logic                          out_restart_report
);
    import ssac_pkg::*;

    // latched request
    logic                ch_reg;
    logic                rdy_reg;
    logic [PERIOD_W-1:0] per_reg;
    logic                lap_reg;

    // per-channel state, and the last speed shared by both channels
    logic [MODE_W-1:0]   mode_reg [2];
    logic                run_reg [2];
    logic [GLITCH_W-1:0] glitch_reg [2];
    logic [ACC_W-1:0]    acc_reg [2];
    logic [SPEED_W-1:0]  shared_reg;

    // result register
    logic                skipped_reg;
    logic [SPEED_W-1:0]  raw_reg;
    logic [ACC_W-1:0]    accepted_reg;
    logic [SPEED_W-1:0]  limit_reg;
    logic [MODE_W-1:0]   pmode_reg;
    logic                changed_reg;
    logic                expired_reg;
    logic                report_reg;

    logic                div_done;
    logic [NUM_W-1:0]    quotient;

    logic [MODE_W-1:0]   mode_cur;
    logic [MODE_W-1:0]   mode_nxt;
    logic [PERIOD_W-1:0] eff_period;
    logic [SPEED_W-1:0]  speed;
    logic                changed;
    logic                report;
    logic [GLITCH_W-1:0] cnt;
    logic [SPEED_W-1:0]  limit;
    logic [SPEED_W-1:0]  diff;
    logic [SPEED_W:0]    delta;
    logic                take;
    logic [ACC_W-1:0]    acc_new;
    logic                skip;

    ssac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (numerator_for(mode_cur)),
        .divisor  (per_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        mode_cur   = mode_reg[ch_reg];
        skip       = !rdy_reg && !lap_reg;
        eff_period = rdy_reg ? per_reg : PERIOD_MAX;

        if (!rdy_reg) begin
            speed = '0;
        end else if (!mode_valid(mode_cur)) begin
            speed = shared_reg;
        end else if (per_reg == '0 || quotient[NUM_W-1:SPEED_W] != '0) begin
            speed = SPEED_MAX;
        end else begin
            speed = quotient[SPEED_W-1:0];
        end

        mode_nxt = next_mode(mode_cur, eff_period);
        changed  = mode_nxt != mode_cur;
        // a timeout or a mode change stops the clock, so it restarts here too
        report   = (!run_reg[ch_reg] || !rdy_reg || changed) && report_mask[ch_reg];

        cnt = glitch_reg[ch_reg] + GLITCH_W'(lap_reg);
        if (cnt == '0) limit = '0;
        else if (cnt == GLITCH_W'(1)) limit = ch_reg ? LIMIT_CH1 : LIMIT_CH0;
        else limit = LIMIT_NONE;

        diff  = {{(SPEED_W-ACC_W){1'b0}}, acc_reg[ch_reg]} - speed;
        delta = diff[SPEED_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
        take  = delta <= {1'b0, limit};

        acc_new = acc_reg[ch_reg];
        if (take) begin
            if (speed < SPEED_FLOOR) acc_new = '0;
            else if (speed <= SPEED_CEIL) acc_new = speed[ACC_W-1:0];
        end
    end

    assign stat.need_div = rdy_reg && mode_valid(mode_cur) && (per_reg != '0);
    assign stat.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg  <= in_channel;
            rdy_reg <= in_capture_ready;
            per_reg <= in_capture_period;
            lap_reg <= in_timer_lapsed;
        end
        if (cmd.commit) begin
            skipped_reg  <= skip;
            raw_reg      <= skip ? '0 : speed;
            accepted_reg <= skip ? acc_reg[ch_reg] : acc_new;
            limit_reg    <= skip ? '0 : limit;
            pmode_reg    <= skip ? mode_cur : mode_nxt;
            changed_reg  <= !skip && changed;
            expired_reg  <= !skip && !rdy_reg;
            report_reg   <= !skip && report;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                mode_reg[i]   <= MODE_RESET;
                run_reg[i]    <= 1'b0;
                glitch_reg[i] <= '0;
                acc_reg[i]    <= '0;
            end
            shared_reg <= '0;
        end else if (cmd.commit && !skip) begin
            mode_reg[ch_reg]   <= mode_nxt;
            run_reg[ch_reg]    <= 1'b1;
            glitch_reg[ch_reg] <= take ? '0 : cnt;
            acc_reg[ch_reg]    <= acc_new;
            shared_reg         <= speed;
        end
    end

    assign out_skipped        = skipped_reg;
    assign out_raw_speed      = raw_reg;
    assign out_accepted_speed = accepted_reg;
    assign out_gate_limit     = limit_reg;
    assign out_prescale_mode  = pmode_reg;
    assign out_mode_changed   = changed_reg;
    assign out_expired_set    = expired_reg;
    assign out_restart_report = report_reg;

endmodule

@@ hdl/ssac_ctrl.sv @@
// controller: sequences request latch, division and result commit
`timescale 1ns / 1ps

module ssac_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ssac_pkg::ssac_cmd_t  cmd,
    input  ssac_pkg::ssac_stat_t stat
);
    import ssac_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

@@ hdl/shaft_speed_autorange_capture_unit.sv @@
// a request is latched in idle, checked in decide and committed in finish; the bit-serial
// 22-step divider runs in between when a division is needed; no new request is taken
// before commit, yet one is taken while the last result waits in the output register
// reset: synchronous active-low aresetn; modes return to 3, speeds, counters and the
// restart mask clear, clocks read as stopped; no clearing pass
`timescale 1ns / 1ps

module shaft_speed_autorange_capture_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_channel,
    input  logic                          s_capture_ready,
    input  logic [ssac_pkg::PERIOD_W-1:0] s_capture_period,
    input  logic                          s_timer_lapsed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_skipped,
    output logic [ssac_pkg::SPEED_W-1:0]  m_raw_speed,
    output logic [ssac_pkg::ACC_W-1:0]    m_accepted_speed,
    output logic [ssac_pkg::SPEED_W-1:0]  m_gate_limit,
    output logic [ssac_pkg::MODE_W-1:0]   m_prescale_mode,
    output logic                          m_mode_changed,
    output logic                          m_expired_set,
    output logic                          m_restart_report,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ssac_pkg::*;

    localparam logic ADDR_REPORT_MASK = 1'b0;

    ssac_cmd_t  cmd;
    ssac_stat_t stat;
    logic [1:0] mask_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_REPORT_MASK) ? {30'b0, mask_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_REPORT_MASK) begin
            mask_reg <= pwdata[1:0];
        end
    end

    ssac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ssac_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .report_mask        (mask_reg),
        .in_channel         (s_channel),
        .in_capture_ready   (s_capture_ready),
        .in_capture_period  (s_capture_period),
        .in_timer_lapsed    (s_timer_lapsed),
        .out_skipped        (m_skipped),
        .out_raw_speed      (m_raw_speed),
        .out_accepted_speed (m_accepted_speed),
        .out_gate_limit     (m_gate_limit),
        .out_prescale_mode  (m_prescale_mode),
        .out_mode_changed   (m_mode_changed),
        .out_expired_set    (m_expired_set),
        .out_restart_report (m_restart_report)
    );

`ifndef ASSERT_OFF
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still in work");

    a_accepted_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_accepted_speed <= ACC_W'(SPEED_CEIL))
        else $error("accepted speed above ceiling");

    a_skip_is_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_skipped |-> m_raw_speed == '0 && m_gate_limit == '0
            && !m_mode_changed && !m_expired_set && !m_restart_report)
        else $error("skipped result carries updates");

    a_mode_after_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_skipped |-> m_prescale_mode == MODE_DIV1
            || m_prescale_mode == MODE_DIV3 || m_prescale_mode == MODE_DIV4)
        else $error("auto-ranging left an invalid mode");
`endif

endmodule
